[sv/piecewise_linear_interpolator_assert.svh]
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
// Assertion helpers for the interpolator.
`define PLI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PLI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[sv/pli_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pli_pkg;
    localparam int unsigned XW = 32;
    localparam int unsigned VW = 48;
    localparam int unsigned PW = 66;
    localparam int unsigned AW = 82;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_EVAL = 2'd1,
        MODE_INTEG = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SEG_RD,
        S_SEG_MUL,
        S_DIV,
        S_EVAL_FIN,
        S_WALK_RD,
        S_WALK_MUL,
        S_WALK_ADD,
        S_LAST_MUL,
        S_LAST_HI,
        S_LAST_ADD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic integ;
        logic [31:0] z;
    } t_query;
endpackage
`default_nettype wire

[sv/pli_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module pli_front
    import pli_pkg::*;
#(
    parameter int unsigned IW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [1:0]    i_mode,
    input  wire logic [3:0]    i_point_index,
    input  wire logic [31:0]   i_point_x,
    input  wire logic [31:0]   i_point_y,
    input  wire logic [31:0]   i_query_point,
    input  wire logic          i_q_pop,
    input  wire logic          i_back_busy,
    output logic               o_busy,
    output logic               o_q_valid,
    output t_query             o_q_data,
    output logic               o_wr_en,
    output logic [IW-1:0]      o_wr_idx,
    output logic [31:0]        o_wr_x,
    output logic [31:0]        o_wr_y
);
    // Two-entry queue of classified queries.
    t_query r_q [2];
    logic [1:0] r_cnt;
    logic r_rd;
    logic r_wrp;
    logic accept;
    logic push;
    logic ld_busy;

    assign ld_busy = (r_cnt != 2'd0) || i_back_busy;
    assign o_busy = (r_cnt == 2'd2) || (t_mode'(i_mode) == MODE_LOAD && ld_busy);
    assign accept = i_start && !o_busy;
    assign push = accept && (t_mode'(i_mode) == MODE_EVAL || t_mode'(i_mode) == MODE_INTEG);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data = r_q[r_rd];
    assign o_wr_en = accept && t_mode'(i_mode) == MODE_LOAD
        && ({28'd0, i_point_index} < 32'(2**IW));
    assign o_wr_idx = IW'(i_point_index);
    assign o_wr_x = i_point_x;
    assign o_wr_y = i_point_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd <= 1'b0;
            r_wrp <= 1'b0;
        end else begin
            if (push) begin
                r_wrp <= !r_wrp;
            end
            if (i_q_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wrp] <= '{integ: (t_mode'(i_mode) == MODE_INTEG), z: i_query_point};
        end
    end
endmodule
`default_nettype wire

[sv/pli_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module pli_back
    import pli_pkg::*;
#(
    parameter int unsigned IW = 4,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [IW:0]   i_n,
    input  wire logic          i_q_valid,
    input  t_query             i_q_data,
    output logic               o_q_pop,
    output logic               o_busy,
    input  wire logic          i_wr_en,
    input  wire logic [IW-1:0] i_wr_idx,
    input  wire logic [31:0]   i_wr_x,
    input  wire logic [31:0]   i_wr_y,
    output logic               o_valid,
    output logic [47:0]        o_value,
    output logic [1:0]         o_status
);
    localparam int unsigned DEPTH = 2**IW;
    localparam int unsigned DLEN = 128;
    localparam int unsigned CW = $clog2(DLEN + 1);

    logic [31:0] r_mx [DEPTH];
    logic [31:0] r_my [DEPTH];
    logic [31:0] r_x0, r_x1, r_y0, r_y1;

    t_state r_st, n_st;
    logic r_integ;
    logic signed [31:0] r_z;
    logic [IW:0] r_lo, r_hi, r_i;
    logic [IW-1:0] rd_idx;
    logic rd_en;
    logic r_neg;
    logic [63:0] r_dx;
    logic [127:0] r_num;
    logic [64:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic signed [AW-1:0] r_acc;
    logic signed [VW-1:0] r_yz;
    logic r_sat;
    logic signed [PW-1:0] r_prod;
    logic signed [33:0] r_ma, r_mb;
    logic signed [48:0] r_lsum;

    logic [IW:0] mid;
    logic signed [32:0] dx_s, dy_s, dz_s;
    logic [32:0] mdx, mdy, mdz;
    logic [64:0] rem_sh;
    logic [128:0] qv, q_s;
    logic signed [129:0] ev_sum;
    logic ev_ok;
    logic signed [VW-1:0] ev_sat;
    logic signed [AW-1:0] sh;
    logic ac_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mx[i_wr_idx] <= i_wr_x;
            r_my[i_wr_idx] <= i_wr_y;
        end
        if (rd_en) begin
            r_x0 <= r_mx[rd_idx];
            r_y0 <= r_my[rd_idx];
            r_x1 <= r_mx[rd_idx + IW'(1)];
            r_y1 <= r_my[rd_idx + IW'(1)];
        end
    end

    assign mid = (IW+1)'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign dx_s = {r_x1[31], r_x1} - {r_x0[31], r_x0};
    assign dy_s = {r_y1[31], r_y1} - {r_y0[31], r_y0};
    assign dz_s = {r_z[31], r_z} - {r_x0[31], r_x0};
    assign mdx = dx_s[32] ? 33'(-dx_s) : 33'(dx_s);
    assign mdy = dy_s[32] ? 33'(-dy_s) : 33'(dy_s);
    assign mdz = dz_s[32] ? 33'(-dz_s) : 33'(dz_s);
    assign rem_sh = {r_rem[63:0], r_num[127]};
    assign qv = {1'b0, r_num};
    assign q_s = r_neg ? 129'(-qv) : qv;
    assign ev_sum = {q_s[128], q_s} + 130'(signed'(r_y0));
    assign ev_ok = (ev_sum[129:47] == '0) || (ev_sum[129:47] == '1);
    assign ev_sat = ev_ok ? ev_sum[47:0] : (ev_sum[129] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});
    assign sh = r_acc >>> (FRACTION_BITS + 1);
    assign ac_ok = (sh[AW-1:47] == '0) || (sh[AW-1:47] == '1);

    always_comb begin
        n_st = r_st;
        rd_en = 1'b0;
        rd_idx = r_lo[IW-1:0];
        o_q_pop = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_st = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                rd_idx = mid[IW-1:0];
                rd_en = 1'b1;
                n_st = (r_hi - r_lo > 1) ? S_SRCH_CMP : S_SEG_RD;
            end
            S_SRCH_CMP: n_st = S_SRCH_RD;
            S_SEG_RD: begin
                rd_en = 1'b1;
                n_st = S_SEG_MUL;
            end
            S_SEG_MUL: n_st = (dx_s == '0) ? S_DONE : S_DIV;
            S_DIV: n_st = (r_cnt == CW'(1)) ? S_EVAL_FIN : S_DIV;
            S_EVAL_FIN: n_st = r_integ ? S_WALK_RD : S_DONE;
            S_WALK_RD: begin
                rd_idx = r_i[IW-1:0];
                rd_en = 1'b1;
                n_st = S_WALK_MUL;
            end
            S_WALK_MUL: begin
                if (({1'b0, r_i} + 2 < {1'b0, i_n}) && $signed(r_x1) < r_z) begin
                    n_st = S_WALK_ADD;
                end else begin
                    n_st = S_LAST_MUL;
                end
            end
            S_WALK_ADD: n_st = S_WALK_RD;
            S_LAST_MUL: n_st = S_LAST_HI;
            S_LAST_HI: n_st = S_LAST_ADD;
            S_LAST_ADD: n_st = S_DONE;
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    assign o_busy = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            o_valid <= 1'b0;
            if (r_st == S_SEG_MUL && dx_s == '0) begin
                o_valid <= 1'b1;
            end
            if (r_st == S_EVAL_FIN && !r_integ) begin
                o_valid <= 1'b1;
            end
            if (r_st == S_LAST_ADD) begin
                o_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_integ <= i_q_data.integ;
                r_z <= i_q_data.z;
                r_lo <= '0;
                r_hi <= i_n - (IW+1)'(1);
                r_sat <= 1'b0;
                r_acc <= '0;
                r_i <= '0;
            end
            S_SRCH_CMP: begin
                if (r_z > $signed(r_x0)) begin
                    r_lo <= mid;
                end else begin
                    r_hi <= mid;
                end
            end
            S_SEG_MUL: begin
                r_num <= {62'd0, 66'(mdy * mdz)};
                r_dx <= {31'd0, mdx};
                r_neg <= dy_s[32] ^ dz_s[32] ^ dx_s[32];
                r_rem <= '0;
                r_cnt <= CW'(DLEN);
                if (dx_s == '0) begin
                    o_value <= '0;
                    o_status <= ST_ZERO;
                end
            end
            S_DIV: begin
                r_cnt <= r_cnt - CW'(1);
                if (rem_sh >= {1'b0, r_dx}) begin
                    r_rem <= rem_sh - {1'b0, r_dx};
                    r_num <= {r_num[126:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_num <= {r_num[126:0], 1'b0};
                end
            end
            S_EVAL_FIN: begin
                r_yz <= ev_sat;
                r_sat <= !ev_ok;
                o_value <= ev_sat;
                o_status <= ev_ok ? ST_OK : ST_SAT;
            end
            S_WALK_MUL: begin
                if (({1'b0, r_i} + 2 < {1'b0, i_n}) && $signed(r_x1) < r_z) begin
                    r_ma <= 34'(signed'(r_y0)) + 34'(signed'(r_y1));
                    r_mb <= 34'(signed'(r_x1)) - 34'(signed'(r_x0));
                end else begin
                    r_lsum <= 49'(r_yz) + 49'(signed'(r_y0));
                    r_mb <= 34'(signed'(r_z)) - 34'(signed'(r_x0));
                end
            end
            S_WALK_ADD: begin
                r_prod <= PW'(r_ma * r_mb);
                r_i <= r_i + (IW+1)'(1);
            end
            S_WALK_RD: begin
                r_acc <= r_acc + AW'(r_prod);
                r_prod <= '0;
            end
            S_LAST_MUL: begin
                r_prod <= '0;
                r_acc <= r_acc + AW'(signed'({1'b0, r_lsum[23:0]}) * r_mb);
            end
            S_LAST_HI: begin
                r_acc <= r_acc + (AW'(signed'(r_lsum[48:24]) * r_mb) <<< 24);
            end
            S_LAST_ADD: begin
                o_value <= ac_ok ? sh[47:0] : (sh[AW-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});
                o_status <= (ac_ok && !r_sat) ? ST_OK : ST_SAT;
            end
            default: begin
            end
        endcase
        if (r_st == S_IDLE) begin
            r_prod <= '0;
        end
    end
endmodule
`default_nettype wire

[sv/piecewise_linear_interpolator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Queries are carried out one at a time by a sequencer behind a two-entry queue: a binary
// search of up to four compare steps, a bit-serial divide of 128 steps, and for integrate a
// walk through read, multiply and add states for each segment passed, then read, multiply,
// two partial-product and add states for the last one. The point count sets the search depth
// and the walk length. A load is taken once the queue is empty and the sequencer is idle.
// Results appear for one cycle on o_valid and cannot be stalled.
module piecewise_linear_interpolator
    import pli_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 16,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [3:0]  i_point_index,
    input  wire logic [31:0] i_point_x,
    input  wire logic [31:0] i_point_y,
    input  wire logic [31:0] i_query_point,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_num_points,
    output logic             o_valid,
    output logic [47:0]      o_value,
    output logic [1:0]       o_status
);
    localparam int unsigned IW = $clog2(MAX_POINTS);

    logic [4:0] r_np;
    logic [IW:0] n_act;
    logic q_pop, q_valid, b_busy, wr_en;
    t_query q_data;
    logic [IW-1:0] wr_idx;
    logic [31:0] wr_x, wr_y;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_np <= 5'd2;
        end else if (i_cfg_valid) begin
            r_np <= i_cfg_num_points;
        end
    end

    assign n_act = (r_np < 5'd2) ? (IW+1)'(2)
        : ((32'(r_np) > MAX_POINTS) ? (IW+1)'(MAX_POINTS) : (IW+1)'(r_np));

    pli_front #(.IW(IW)) u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_mode, .i_point_index, .i_point_x,
        .i_point_y, .i_query_point, .i_q_pop(q_pop), .i_back_busy(b_busy),
        .o_busy(busy), .o_q_valid(q_valid), .o_q_data(q_data), .o_wr_en(wr_en),
        .o_wr_idx(wr_idx), .o_wr_x(wr_x), .o_wr_y(wr_y)
    );

    pli_back #(.IW(IW), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n, .i_n(n_act), .i_q_valid(q_valid), .i_q_data(q_data),
        .o_q_pop(q_pop), .o_busy(b_busy), .i_wr_en(wr_en), .i_wr_idx(wr_idx),
        .i_wr_x(wr_x), .i_wr_y(wr_y), .o_valid, .o_value, .o_status
    );

`include "piecewise_linear_interpolator_assert.svh"
    `PLI_ASSERT_IMPL(a_status, o_valid, o_status != 2'd3)
    `PLI_ASSERT_NEXT(a_pulse, o_valid, !o_valid)
    `PLI_ASSERT_IMPL(a_zero, o_valid && o_status == ST_ZERO, o_value == '0)
endmodule
`default_nettype wire
